// ===== design/adst_pkg.sv =====
// Shared types and codes for the aging sighting table.
// Holds the table entry layout, controller commands, datapath status and result codes.
package adst_pkg;

    typedef struct packed {
        logic [47:0]       addr;
        logic signed [7:0] dbm;
        logic [15:0]       seen;
        logic [31:0]       first_ms;
        logic [31:0]       last_ms;
        logic              ble;
    } entry_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_SCAN_RD,
        CMD_SCAN_NEXT,
        CMD_HIT,
        CMD_SHIFT_INIT,
        CMD_SHIFT_RD,
        CMD_SHIFT_WR,
        CMD_INSERT,
        CMD_SORT_INIT,
        CMD_SORT_RD_I,
        CMD_SORT_KEY,
        CMD_SORT_RD_J,
        CMD_SORT_MOVE,
        CMD_SORT_PLACE,
        CMD_SORT_DONE,
        CMD_READ_RD,
        CMD_READ_OUT,
        CMD_READ_EMPTY
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       count_zero;
        logic       hit;
        logic       scan_last;
        logic       idx_zero;
        logic       sort_end;
        logic       j_zero;
        logic       key_greater;
        logic       read_ok;
    } dp_status_t;

    localparam logic [1:0] FUNC_OBSERVE = 2'd0;
    localparam logic [1:0] FUNC_SORT    = 2'd1;
    localparam logic [1:0] FUNC_READ    = 2'd2;
    localparam logic [1:0] FUNC_SPARE   = 2'd3;

    localparam logic [2:0] ST_INSERTED   = 3'd0;
    localparam logic [2:0] ST_MERGED     = 3'd1;
    localparam logic [2:0] ST_DROPPED    = 3'd2;
    localparam logic [2:0] ST_READ_OK    = 3'd3;
    localparam logic [2:0] ST_READ_EMPTY = 3'd4;
    localparam logic [2:0] ST_SORTED     = 3'd5;

    localparam logic CFG_WINDOW = 1'b0;
    localparam logic CFG_MAX    = 1'b1;

endpackage

// ===== design/adst_ctrl.sv =====
// Controller state machine for the aging sighting table.
// Depends on adst_pkg; drives one command per cycle into adst_dpath.
module adst_ctrl import adst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  dp_status_t st,
    output cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_INIT,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SORT_NEXT,
        S_SORT_KEY,
        S_SORT_RD,
        S_SORT_CMP,
        S_READ_RD,
        S_READ_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd        = CMD_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (st.func)
                    FUNC_OBSERVE:
                    begin
                        state_next = st.count_zero ? S_SHIFT_INIT : S_SCAN_RD;
                    end
                    FUNC_SORT:
                    begin
                        cmd        = CMD_SORT_INIT;
                        state_next = S_SORT_NEXT;
                    end
                    default:
                    begin
                        if (st.read_ok)
                        begin
                            state_next = S_READ_RD;
                        end
                        else
                        begin
                            cmd        = CMD_READ_EMPTY;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                cmd        = CMD_SCAN_RD;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (st.hit)
                begin
                    cmd        = CMD_HIT;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd        = CMD_SCAN_NEXT;
                    state_next = st.scan_last ? S_SHIFT_INIT : S_SCAN_RD;
                end
            end
            S_SHIFT_INIT:
            begin
                cmd        = CMD_SHIFT_INIT;
                state_next = S_SHIFT_RD;
            end
            S_SHIFT_RD:
            begin
                if (st.idx_zero)
                begin
                    cmd        = CMD_INSERT;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd        = CMD_SHIFT_RD;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd        = CMD_SHIFT_WR;
                state_next = S_SHIFT_RD;
            end
            S_SORT_NEXT:
            begin
                if (st.sort_end)
                begin
                    cmd        = CMD_SORT_DONE;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd        = CMD_SORT_RD_I;
                    state_next = S_SORT_KEY;
                end
            end
            S_SORT_KEY:
            begin
                cmd        = CMD_SORT_KEY;
                state_next = S_SORT_RD;
            end
            S_SORT_RD:
            begin
                if (st.j_zero)
                begin
                    cmd        = CMD_SORT_PLACE;
                    state_next = S_SORT_NEXT;
                end
                else
                begin
                    cmd        = CMD_SORT_RD_J;
                    state_next = S_SORT_CMP;
                end
            end
            S_SORT_CMP:
            begin
                if (st.key_greater)
                begin
                    cmd        = CMD_SORT_MOVE;
                    state_next = S_SORT_RD;
                end
                else
                begin
                    cmd        = CMD_SORT_PLACE;
                    state_next = S_SORT_NEXT;
                end
            end
            S_READ_RD:
            begin
                cmd        = CMD_READ_RD;
                state_next = S_READ_OUT;
            end
            S_READ_OUT:
            begin
                cmd        = CMD_READ_OUT;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== design/adst_dpath.sv =====
// Datapath of the aging sighting table: entry memory, indexes, settings and result registers.
// Depends on adst_pkg; executes the commands issued by adst_ctrl.
module adst_dpath import adst_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [31:0]       cfg_wdata,
    input  cmd_t              cmd,
    output dp_status_t        st,
    input  logic [1:0]        func,
    input  logic [47:0]       device_addr,
    input  logic signed [7:0] signal_dbm,
    input  logic [31:0]       now_ms,
    input  logic              from_ble,
    input  logic [5:0]        read_slot,
    output logic              done,
    output logic [2:0]        status,
    output logic [5:0]        slot,
    output entry_t            entry,
    output logic [6:0]        occupancy
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int RW = (CW > 6) ? CW : 6;
    localparam int EW = ((CW > 7) ? CW : 7) + 1;

    entry_t mem [TABLE_DEPTH];

    logic [31:0]       window_reg;
    logic [6:0]        max_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [IW-1:0]     j_reg, j_next;
    logic [1:0]        func_reg, func_next;
    logic [47:0]       addr_reg, addr_next;
    logic signed [7:0] dbm_reg, dbm_next;
    logic [31:0]       now_reg, now_next;
    logic              ble_reg, ble_next;
    logic [5:0]        rs_reg, rs_next;
    entry_t            key_reg, key_next;
    entry_t            rd_reg;
    logic              done_reg, done_next;
    logic [2:0]        status_reg, status_next;
    logic [5:0]        slot_reg, slot_next;
    entry_t            entry_reg, entry_next;
    logic [6:0]        occ_reg, occ_next;

    logic          rd_en, wr_en;
    logic [IW-1:0] rd_addr, wr_addr;
    entry_t        wr_data;
    entry_t        new_entry, hit_entry;
    logic [31:0]   age;
    logic [EW-1:0] max_ext, lim, count_inc, count_after;
    logic          ins_drop;
    logic [CW-1:0] shift_start;

    assign age = now_reg - rd_reg.last_ms;

    assign st.func        = func_reg;
    assign st.count_zero  = (count_reg == '0);
    assign st.hit         = (rd_reg.addr == addr_reg) && (age < window_reg);
    assign st.scan_last   = ((idx_reg + CW'(1)) == count_reg);
    assign st.idx_zero    = (idx_reg == '0);
    assign st.sort_end    = (idx_reg >= count_reg);
    assign st.j_zero      = (j_reg == '0);
    assign st.key_greater = ($signed(key_reg.dbm) > $signed(rd_reg.dbm));
    assign st.read_ok     = (RW'(rs_reg) < RW'(count_reg));

    always_comb
    begin
        new_entry.addr     = addr_reg;
        new_entry.dbm      = dbm_reg;
        new_entry.seen     = 16'd1;
        new_entry.first_ms = now_reg;
        new_entry.last_ms  = now_reg;
        new_entry.ble      = ble_reg;

        hit_entry         = rd_reg;
        hit_entry.dbm     = dbm_reg;
        hit_entry.seen    = (rd_reg.seen == 16'hFFFF) ? rd_reg.seen : rd_reg.seen + 16'd1;
        hit_entry.last_ms = now_reg;

        max_ext     = EW'(max_reg);
        if (max_ext == '0)
        begin
            lim = EW'(1);
        end
        else if (max_ext > EW'(TABLE_DEPTH))
        begin
            lim = EW'(TABLE_DEPTH);
        end
        else
        begin
            lim = max_ext;
        end
        count_inc   = EW'(count_reg) + EW'(1);
        ins_drop    = (count_inc > lim);
        count_after = ins_drop ? lim : count_inc;
        shift_start = (count_reg > CW'(TABLE_DEPTH - 1)) ? CW'(TABLE_DEPTH - 1) : count_reg;
    end

    always_comb
    begin
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = rd_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        j_next      = j_reg;
        func_next   = func_reg;
        addr_next   = addr_reg;
        dbm_next    = dbm_reg;
        now_next    = now_reg;
        ble_next    = ble_reg;
        rs_next     = rs_reg;
        key_next    = key_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        slot_next   = slot_reg;
        entry_next  = entry_reg;
        occ_next    = occ_reg;
        case (cmd)
            CMD_LATCH:
            begin
                func_next = func;
                addr_next = device_addr;
                dbm_next  = signal_dbm;
                now_next  = now_ms;
                ble_next  = from_ble;
                rs_next   = read_slot;
                idx_next  = '0;
            end
            CMD_SCAN_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = IW'(idx_reg);
            end
            CMD_SCAN_NEXT:
            begin
                idx_next = idx_reg + CW'(1);
            end
            CMD_HIT:
            begin
                wr_en       = 1'b1;
                wr_addr     = IW'(idx_reg);
                wr_data     = hit_entry;
                done_next   = 1'b1;
                status_next = ST_MERGED;
                slot_next   = 6'(idx_reg);
                entry_next  = hit_entry;
                occ_next    = 7'(count_reg);
            end
            CMD_SHIFT_INIT:
            begin
                idx_next = shift_start;
            end
            CMD_SHIFT_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = IW'(idx_reg - CW'(1));
            end
            CMD_SHIFT_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = IW'(idx_reg);
                wr_data  = rd_reg;
                idx_next = idx_reg - CW'(1);
            end
            CMD_INSERT:
            begin
                wr_en       = 1'b1;
                wr_addr     = '0;
                wr_data     = new_entry;
                count_next  = CW'(count_after);
                done_next   = 1'b1;
                status_next = ins_drop ? ST_DROPPED : ST_INSERTED;
                slot_next   = '0;
                entry_next  = new_entry;
                occ_next    = 7'(count_after);
            end
            CMD_SORT_INIT:
            begin
                idx_next = CW'(1);
            end
            CMD_SORT_RD_I:
            begin
                rd_en   = 1'b1;
                rd_addr = IW'(idx_reg);
                j_next  = IW'(idx_reg);
            end
            CMD_SORT_KEY:
            begin
                key_next = rd_reg;
            end
            CMD_SORT_RD_J:
            begin
                rd_en   = 1'b1;
                rd_addr = j_reg - IW'(1);
            end
            CMD_SORT_MOVE:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg;
                wr_data = rd_reg;
                j_next  = j_reg - IW'(1);
            end
            CMD_SORT_PLACE:
            begin
                wr_en    = 1'b1;
                wr_addr  = j_reg;
                wr_data  = key_reg;
                idx_next = idx_reg + CW'(1);
            end
            CMD_SORT_DONE:
            begin
                done_next   = 1'b1;
                status_next = ST_SORTED;
                slot_next   = '0;
                entry_next  = '0;
                occ_next    = 7'(count_reg);
            end
            CMD_READ_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = IW'(rs_reg);
            end
            CMD_READ_OUT:
            begin
                done_next   = 1'b1;
                status_next = ST_READ_OK;
                slot_next   = rs_reg;
                entry_next  = rd_reg;
                occ_next    = 7'(count_reg);
            end
            CMD_READ_EMPTY:
            begin
                done_next   = 1'b1;
                status_next = ST_READ_EMPTY;
                slot_next   = rs_reg;
                entry_next  = '0;
                occ_next    = 7'(count_reg);
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
        j_reg      <= j_next;
        func_reg   <= func_next;
        addr_reg   <= addr_next;
        dbm_reg    <= dbm_next;
        now_reg    <= now_next;
        ble_reg    <= ble_next;
        rs_reg     <= rs_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        entry_reg  <= entry_next;
        occ_reg    <= occ_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= 32'd30000;
            max_reg    <= 7'd50;
            count_reg  <= '0;
            idx_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_addr == CFG_WINDOW))
            begin
                window_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_addr == CFG_MAX))
            begin
                max_reg <= cfg_wdata[6:0];
            end
            count_reg <= count_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;
    assign entry     = entry_reg;
    assign occupancy = occ_reg;

endmodule

// ===== design/aging_dedup_sighting_table.sv =====
// Top level of the aging sighting table with duplicate merge.
// Depends on adst_pkg, adst_ctrl and adst_dpath.
//
// Channel   Handshake         Ports
// config    cfg_we            cfg_addr, cfg_wdata
// request   start, busy       func, device_addr, signal_dbm, now_ms, from_ble, read_slot
// result    done (1 cycle)    status, slot, entry_*, occupancy
//
// One request at a time; the entry memory has one read and one write port.
// A read fetches one entry, a merge first scans the entries up to its position, an insert
// scans every entry and then shifts them down by one slot, and a sort places each entry
// past the first in turn.
// The result strobe comes in the cycle after the last step; the receiver cannot stall.
// Reset clears the entry count and restores the default settings at once.
module aging_dedup_sighting_table import adst_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [31:0]       cfg_wdata,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        func,
    input  logic [47:0]       device_addr,
    input  logic signed [7:0] signal_dbm,
    input  logic [31:0]       now_ms,
    input  logic              from_ble,
    input  logic [5:0]        read_slot,
    output logic              done,
    output logic [2:0]        status,
    output logic [5:0]        slot,
    output logic [47:0]       entry_addr,
    output logic signed [7:0] entry_dbm,
    output logic [15:0]       entry_seen,
    output logic [31:0]       entry_first_ms,
    output logic [31:0]       entry_last_ms,
    output logic              entry_ble,
    output logic [6:0]        occupancy
);

    cmd_t       cmd;
    dp_status_t st;
    entry_t     entry;

    adst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .st    (st),
        .cmd   (cmd)
    );

    adst_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .st          (st),
        .func        (func),
        .device_addr (device_addr),
        .signal_dbm  (signal_dbm),
        .now_ms      (now_ms),
        .from_ble    (from_ble),
        .read_slot   (read_slot),
        .done        (done),
        .status      (status),
        .slot        (slot),
        .entry       (entry),
        .occupancy   (occupancy)
    );

    assign entry_addr     = entry.addr;
    assign entry_dbm      = entry.dbm;
    assign entry_seen     = entry.seen;
    assign entry_first_ms = entry.first_ms;
    assign entry_last_ms  = entry.last_ms;
    assign entry_ble      = entry.ble;

endmodule

// ===== design/adst_checker.sv =====
// Port-level checks for the aging sighting table, attached by bind.
// Depends on adst_pkg for the result codes.
module adst_checker import adst_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [2:0] status,
    input logic [5:0] slot,
    input logic [6:0] occupancy
);

    localparam int OCC_MAX = (TABLE_DEPTH > 127) ? 127 : TABLE_DEPTH;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status <= ST_SORTED))
        else $error("result status out of range");

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(occupancy) <= OCC_MAX || TABLE_DEPTH > 127))
        else $error("occupancy beyond table depth");

    a_insert_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_INSERTED || status == ST_DROPPED || status == ST_SORTED))
            |-> (slot == 6'd0))
        else $error("insert or sort result with nonzero slot");

endmodule

bind aging_dedup_sighting_table adst_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_adst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .slot      (slot),
    .occupancy (occupancy)
);

// ===== tb/aging_dedup_sighting_table_test.sv =====
// Self-checking testbench for the aging sighting table with duplicate merge.
// Depends on adst_pkg and the aging_dedup_sighting_table design; a scoreboard
// class predicts each result and checks it against the done strobe.
module aging_dedup_sighting_table_test;
    import adst_pkg::*;

    localparam int DEPTH = 64;
    localparam int CYCLE_LIMIT = 40000000;

    typedef struct packed {
        logic [2:0]        status;
        logic [5:0]        slot;
        logic [47:0]       addr;
        logic signed [7:0] dbm;
        logic [15:0]       seen;
        logic [31:0]       first_ms;
        logic [31:0]       last_ms;
        logic              ble;
        logic [6:0]        occupancy;
    } sighting_result_t;

    class sighting_scoreboard;
        entry_t           table_q[DEPTH];
        int unsigned      count;
        logic [31:0]      window;
        logic [6:0]       max_cfg;
        sighting_result_t awaited[$];

        function void clear();
            count = 0;
            window = 32'd30000;
            max_cfg = 7'd50;
            awaited.delete();
        endfunction

        function int unsigned limit();
            int unsigned lim;
            lim = 32'(max_cfg);
            if (lim == 0) lim = 1;
            if (lim > DEPTH) lim = DEPTH;
            return lim;
        endfunction

        function void fill(inout sighting_result_t r, input int unsigned i);
            r.addr = table_q[i].addr;
            r.dbm = table_q[i].dbm;
            r.seen = table_q[i].seen;
            r.first_ms = table_q[i].first_ms;
            r.last_ms = table_q[i].last_ms;
            r.ble = table_q[i].ble;
        endfunction

        function void note_request(logic [1:0] f, logic [47:0] a, logic [7:0] d,
                                   logic [31:0] now, logic b, logic [5:0] rs);
            sighting_result_t r;
            entry_t key;
            int unsigned n;
            int j;
            bit merged;
            r = '0;
            merged = 0;
            if (f == FUNC_OBSERVE) begin
                for (int i = 0; i < count && !merged; i++) begin
                    if (table_q[i].addr == a && (now - table_q[i].last_ms) < window) begin
                        table_q[i].dbm = d;
                        if (table_q[i].seen != 16'hFFFF) table_q[i].seen++;
                        table_q[i].last_ms = now;
                        r.status = ST_MERGED;
                        r.slot = 6'(i);
                        fill(r, i);
                        merged = 1;
                    end
                end
                if (!merged) begin
                    n = (count > DEPTH - 1) ? DEPTH - 1 : count;
                    for (int i = n; i > 0; i--) table_q[i] = table_q[i - 1];
                    table_q[0] = '{addr: a, dbm: d, seen: 16'd1, first_ms: now,
                                   last_ms: now, ble: b};
                    n = count + 1;
                    r.status = ST_INSERTED;
                    if (n > limit()) begin
                        n = limit();
                        r.status = ST_DROPPED;
                    end
                    count = n;
                    r.slot = 0;
                    fill(r, 0);
                end
            end else if (f == FUNC_SORT) begin
                for (int i = 1; i < count; i++) begin
                    key = table_q[i];
                    j = i;
                    while (j > 0 && $signed(key.dbm) > $signed(table_q[j - 1].dbm)) begin
                        table_q[j] = table_q[j - 1];
                        j--;
                    end
                    table_q[j] = key;
                end
                r.status = ST_SORTED;
            end else begin
                r.slot = rs;
                if (rs < count) begin
                    fill(r, rs);
                    r.status = ST_READ_OK;
                end else begin
                    r.status = ST_READ_EMPTY;
                end
            end
            r.occupancy = 7'(count);
            awaited.push_back(r);
        endfunction

        function string check_result(sighting_result_t got);
            sighting_result_t e;
            if (awaited.size() == 0) return "result with no request outstanding";
            e = awaited.pop_front();
            if (got.status !== e.status)
                return $sformatf("status %0d, expected %0d", got.status, e.status);
            if (got.slot !== e.slot)
                return $sformatf("slot %0d, expected %0d", got.slot, e.slot);
            if (got.addr !== e.addr)
                return $sformatf("entry_addr %h, expected %h", got.addr, e.addr);
            if (got.dbm !== e.dbm)
                return $sformatf("entry_dbm %0d, expected %0d", got.dbm, e.dbm);
            if (got.seen !== e.seen)
                return $sformatf("entry_seen %0d, expected %0d", got.seen, e.seen);
            if (got.first_ms !== e.first_ms)
                return $sformatf("entry_first_ms %h, expected %h", got.first_ms, e.first_ms);
            if (got.last_ms !== e.last_ms)
                return $sformatf("entry_last_ms %h, expected %h", got.last_ms, e.last_ms);
            if (got.ble !== e.ble)
                return $sformatf("entry_ble %b, expected %b", got.ble, e.ble);
            if (got.occupancy !== e.occupancy)
                return $sformatf("occupancy %0d, expected %0d", got.occupancy, e.occupancy);
            return "";
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_addr;
    logic [31:0]       cfg_wdata;
    logic              start;
    logic              busy;
    logic [1:0]        func;
    logic [47:0]       device_addr;
    logic signed [7:0] signal_dbm;
    logic [31:0]       now_ms;
    logic              from_ble;
    logic [5:0]        read_slot;
    logic              done;
    logic [2:0]        status;
    logic [5:0]        slot;
    logic [47:0]       entry_addr;
    logic signed [7:0] entry_dbm;
    logic [15:0]       entry_seen;
    logic [31:0]       entry_first_ms;
    logic [31:0]       entry_last_ms;
    logic              entry_ble;
    logic [6:0]        occupancy;

    sighting_scoreboard sb;
    int                 mismatches;
    int                 cycles;
    bit                 idling_on;
    logic [31:0]        clock_ms;
    logic [47:0]        addr_pool[12];

    aging_dedup_sighting_table uut (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    task automatic report(string msg);
        mismatches++;
        $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    always @(posedge clk)
    begin
        string msg;
        if (rst_n && start && !busy)
            sb.note_request(func, device_addr, signal_dbm, now_ms, from_ble, read_slot);
        if (rst_n && done) begin
            msg = sb.check_result('{status, slot, entry_addr, entry_dbm, entry_seen,
                                    entry_first_ms, entry_last_ms, entry_ble, occupancy});
            if (msg != "") report(msg);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_request(logic [1:0] f, logic [47:0] a, logic [7:0] d,
                                logic [31:0] now, logic b, logic [5:0] rs);
        if (idling_on && $urandom_range(0, 99) < 18) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        func <= f;
        device_addr <= a;
        signal_dbm <= d;
        now_ms <= now;
        from_ble <= b;
        read_slot <= rs;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_config(logic idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WINDOW) sb.window = value;
        else sb.max_cfg = value[6:0];
        @(posedge clk);
    endtask

    task automatic random_phase(int items, int first_index);
        logic [1:0]  f;
        logic [47:0] a;
        int          pick;
        for (int k = 0; k < 12; k++) addr_pool[k] = 48'({$urandom, $urandom});
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int k = 0; k < items; k++) begin
            idling_on = !((first_index + k) >= 400 && (first_index + k) < 700);
            pick = $urandom_range(0, 99);
            if (pick < 70) f = FUNC_OBSERVE;
            else if (pick < 73) f = FUNC_SORT;
            else if (pick < 97) f = FUNC_READ;
            else f = FUNC_SPARE;
            a = ($urandom_range(0, 3) == 0) ? 48'({$urandom, $urandom})
                                             : addr_pool[$urandom_range(0, 11)];
            if ($urandom_range(0, 9) == 0) clock_ms = clock_ms + $urandom;
            else clock_ms = clock_ms + $urandom_range(0, 1500);
            send_request(f, a, 8'($urandom), clock_ms, 1'($urandom),
                         ($urandom_range(0, 3) == 0) ? 6'($urandom)
                                                     : 6'($urandom_range(0, 15)));
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        mismatches = 0;
        cycles = 0;
        idling_on = 1;
        clock_ms = 32'hFFFF_FF00;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_addr <= 1'b0;
        cfg_wdata <= '0;
        start <= 1'b0;
        func <= '0;
        device_addr <= '0;
        signal_dbm <= '0;
        now_ms <= '0;
        from_ble <= 1'b0;
        read_slot <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        send_request(FUNC_READ, '0, '0, '0, 1'b0, 6'd0);
        send_request(FUNC_READ, '1, '1, '1, 1'b1, 6'd63);
        send_request(FUNC_SORT, '0, '0, '0, 1'b0, 6'd0);
        send_request(FUNC_OBSERVE, '0, 8'h80, 32'h0000_0000, 1'b0, 6'd0);
        send_request(FUNC_OBSERVE, '1, 8'h7F, 32'hFFFF_FFFF, 1'b1, 6'd63);
        send_request(FUNC_OBSERVE, '0, 8'h7F, 32'h0000_0100, 1'b1, 6'd0);
        send_request(FUNC_OBSERVE, '1, 8'h00, 32'h0000_0010, 1'b0, 6'd0);
        send_request(FUNC_OBSERVE, 48'h1234_5678_9ABC, 8'hF0, 32'h0001_0000, 1'b1, 6'd0);
        send_request(FUNC_OBSERVE, '0, 8'h01, 32'h0002_0000, 1'b0, 6'd0);
        send_request(FUNC_OBSERVE, 48'hAAAA_5555_AAAA, 8'h7F, 32'h0002_0001, 1'b0, 6'd0);
        send_request(FUNC_OBSERVE, 48'h5555_AAAA_5555, 8'h80, 32'h0002_0002, 1'b1, 6'd0);
        send_request(FUNC_SORT, '0, '0, '0, 1'b0, 6'd0);
        for (int k = 0; k < 7; k++) send_request(FUNC_READ, '0, '0, '0, 1'b0, 6'(k));
        send_request(FUNC_SPARE, '0, '0, '0, 1'b0, 6'd1);
        send_request(FUNC_SPARE, '0, '0, '0, 1'b0, 6'd40);
        drain();

        write_config(CFG_WINDOW, 32'd0);
        write_config(CFG_MAX, 32'd3);
        send_request(FUNC_OBSERVE, '0, 8'h10, 32'h0002_0003, 1'b0, 6'd0);
        send_request(FUNC_OBSERVE, '0, 8'h11, 32'h0002_0003, 1'b1, 6'd0);
        send_request(FUNC_READ, '0, '0, '0, 1'b0, 6'd2);
        drain();

        write_config(CFG_WINDOW, 32'd1000);
        write_config(CFG_MAX, 32'd8);
        random_phase(300, 0);
        drain();
        write_config(CFG_WINDOW, 32'hFFFF_FFFF);
        write_config(CFG_MAX, 32'd64);
        random_phase(300, 300);
        drain();
        write_config(CFG_WINDOW, 32'd0);
        write_config(CFG_MAX, 32'd1);
        random_phase(200, 600);
        drain();
        write_config(CFG_WINDOW, 32'd500);
        write_config(CFG_MAX, 32'd0);
        random_phase(150, 800);
        drain();
        write_config(CFG_WINDOW, 32'd30000);
        write_config(CFG_MAX, 32'd127);
        random_phase(400, 950);
        drain();
        write_config(CFG_WINDOW, 32'd1);
        write_config(CFG_MAX, 32'd50);
        random_phase(250, 1350);
        drain();
        write_config(CFG_WINDOW, 32'd2000);
        write_config(CFG_MAX, 32'd5);
        random_phase(280, 1600);
        drain();
        repeat (100) @(posedge clk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== sim.f =====
design/adst_pkg.sv
design/adst_ctrl.sv
design/adst_dpath.sv
design/aging_dedup_sighting_table.sv
design/adst_checker.sv
tb/aging_dedup_sighting_table_test.sv
